@@ design/s5hs_pkg.sv @@
`timescale 1ns / 1ps

package s5hs_pkg;

  // Result kinds, carried on m_axis_tuser
  localparam logic [2:0] KIND_PASS  = 3'd0;
  localparam logic [2:0] KIND_REPLY = 3'd1;
  localparam logic [2:0] KIND_DEST  = 3'd2;
  localparam logic [2:0] KIND_PORT  = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_INCOMPLETE  = 3'd0;
  localparam logic [2:0] ERR_BAD_VERSION = 3'd1;
  localparam logic [2:0] ERR_NO_AUTH     = 3'd2;
  localparam logic [2:0] ERR_BAD_COMMAND = 3'd3;
  localparam logic [2:0] ERR_BAD_ATYP    = 3'd4;

  // Destination types on the result side
  localparam logic [1:0] DTYPE_IPV4   = 2'd0;
  localparam logic [1:0] DTYPE_DOMAIN = 2'd1;
  localparam logic [1:0] DTYPE_IPV6   = 2'd2;

  // Session phases
  localparam logic [1:0] PH_GREET = 2'd0;
  localparam logic [1:0] PH_REQ   = 2'd1;
  localparam logic [1:0] PH_FWD   = 2'd2;

  // Tail part of a result burst
  localparam logic [1:0] TAIL_NONE  = 2'd0;
  localparam logic [1:0] TAIL_ERR   = 2'd1;
  localparam logic [1:0] TAIL_GREET = 2'd2;
  localparam logic [1:0] TAIL_CONN  = 2'd3;

  // Protocol constants
  localparam logic [7:0] SOCKS_VER    = 8'd5;
  localparam logic [7:0] CMD_CONNECT  = 8'd1;
  localparam logic [7:0] ATYP_IPV4    = 8'd1;
  localparam logic [7:0] ATYP_DOMAIN  = 8'd3;
  localparam logic [7:0] ATYP_IPV6    = 8'd4;
  localparam logic [7:0] METHOD_NONE  = 8'd0;

  localparam logic [8:0] CNT_MAX      = 9'd511;
  localparam logic [8:0] REQ_LEN_V4   = 9'd10;
  localparam logic [8:0] REQ_LEN_V6   = 9'd22;
  localparam logic [8:0] DOMAIN_EXTRA = 9'd7;
  localparam logic [8:0] GREET_EXTRA  = 9'd2;
  localparam logic [8:0] ADDR_START   = 9'd4;
  localparam logic [8:0] DOMAIN_START = 9'd5;
  localparam logic [8:0] V4_ADDR_END  = 9'd8;
  localparam logic [8:0] V6_ADDR_END  = 9'd20;

  // Burst lengths (port result plus reply bytes)
  localparam logic [4:0] CONN_LEN_V4  = 5'd11;
  localparam logic [4:0] CONN_LEN_V6  = 5'd23;

endpackage

@@ design/socks5_server_handshake_unit.sv @@
`timescale 1ns / 1ps
// The first result of an input item is presented in the cycle after the item is accepted.
// Throughput: one input item per cycle while each item yields at most one result and m_axis_tready is high.
// A handshake reply burst (2, 11 or 23 results) holds s_axis_tready low until its last
// result is taken; the burst register is the only result buffer.
// Reset (rst, synchronous): greeting phase, message state cleared, pending results dropped.
module socks5_server_handshake_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // message_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] result_byte, [23:8] dest_port,
                                      // [25:24] dest_type, [28:26] error_kind, rest zero
  output logic [2:0]  m_axis_tuser,   // [2:0] result_kind
  output logic        m_axis_tlast    // run_end
);
  import s5hs_pkg::*;

  // Session and message state
  logic [1:0] phase, phase_next;
  logic [8:0] byte_count, byte_count_next;
  logic       version_bad, version_bad_next;
  logic [7:0] count_or_length, count_or_length_next;
  logic       no_auth_seen, no_auth_seen_next;
  logic       command_bad, command_bad_next;
  logic [7:0] address_kind, address_kind_next;
  logic [7:0] port_high, port_high_next;

  // Pending burst
  logic       job_valid;
  logic [4:0] pos;
  logic [4:0] job_last;
  logic       job_lead;
  logic [2:0] job_lead_kind;
  logic [7:0] job_byte;
  logic [1:0] job_type;
  logic [1:0] job_tail;
  logic [2:0] job_err;
  logic [15:0] job_port;
  logic [1:0] job_ptype;
  logic       job_ipv6;

  // Values for a burst to load
  logic       ld_lead;
  logic [2:0] ld_lead_kind;
  logic [1:0] ld_type;
  logic [1:0] ld_tail;
  logic [2:0] ld_err;
  logic [1:0] ld_ptype;
  logic       ld_ipv6;
  logic [4:0] ld_tail_len;
  logic [4:0] ld_len;
  logic       ld_has;

  logic       in_accept;
  logic       out_take;
  logic       out_is_last;

  logic [7:0] b;
  logic [8:0] idx;
  logic [8:0] size;
  logic       vb_cur;
  logic       cb_cur;
  logic [7:0] ak_cur;
  logic [7:0] len_cur;
  logic       na_cur;
  logic       addr_v4, addr_dom, addr_v6;

  logic [4:0] t;
  logic [2:0] r_kind;
  logic [7:0] r_byte;
  logic [15:0] r_port;
  logic [1:0] r_type;
  logic [2:0] r_err;

  assign b           = s_axis_tdata;
  assign idx         = byte_count;
  assign out_is_last = (pos == job_last);
  assign out_take    = job_valid && m_axis_tready;
  assign s_axis_tready = !job_valid || (m_axis_tready && out_is_last);
  assign in_accept   = s_axis_tvalid && s_axis_tready;

  // Saturating message size including this byte
  assign size = (byte_count == CNT_MAX) ? byte_count : byte_count + 9'd1;

  // Field captures as seen with this byte included
  assign vb_cur  = (idx == 9'd0) ? (b != SOCKS_VER) : version_bad;
  assign cb_cur  = (idx == 9'd1) ? (b != CMD_CONNECT) : command_bad;
  assign ak_cur  = (idx == 9'd3) ? b : address_kind;
  assign len_cur = (phase == PH_REQ) ? ((idx == 9'd4) ? b : count_or_length)
                                     : ((idx == 9'd1) ? b : count_or_length);
  assign na_cur  = no_auth_seen || ((idx >= 9'd2) && (b == METHOD_NONE));

  // Address byte windows by address type
  assign addr_v4  = (ak_cur == ATYP_IPV4) && (idx >= ADDR_START) && (idx < V4_ADDR_END);
  assign addr_dom = (ak_cur == ATYP_DOMAIN) && (idx >= DOMAIN_START)
                    && (idx < DOMAIN_START + {1'b0, len_cur});
  assign addr_v6  = (ak_cur == ATYP_IPV6) && (idx >= ADDR_START) && (idx < V6_ADDR_END);

  // Parse one byte: next state and the burst it causes
  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    version_bad_next     = version_bad;
    count_or_length_next = count_or_length;
    no_auth_seen_next    = no_auth_seen;
    command_bad_next     = command_bad;
    address_kind_next    = address_kind;
    port_high_next       = port_high;
    ld_lead      = 1'b0;
    ld_lead_kind = KIND_PASS;
    ld_type      = DTYPE_IPV4;
    ld_tail      = TAIL_NONE;
    ld_err       = ERR_INCOMPLETE;
    ld_ptype     = DTYPE_IPV4;
    ld_ipv6      = 1'b0;

    if (phase == PH_FWD) begin
      ld_lead = 1'b1;
    end else if (phase == PH_REQ) begin
      byte_count_next      = size;
      version_bad_next     = vb_cur;
      command_bad_next     = cb_cur;
      address_kind_next    = ak_cur;
      count_or_length_next = len_cur;
      port_high_next       = b;
      if (addr_v4 || addr_dom || addr_v6) begin
        ld_lead      = 1'b1;
        ld_lead_kind = KIND_DEST;
        ld_type      = addr_dom ? DTYPE_DOMAIN : (addr_v6 ? DTYPE_IPV6 : DTYPE_IPV4);
      end
      if (s_axis_tlast) begin
        ld_tail = TAIL_ERR;
        if (size < REQ_LEN_V4) begin
          ld_err = ERR_INCOMPLETE;
        end else if (vb_cur) begin
          ld_err = ERR_BAD_VERSION;
        end else if (cb_cur) begin
          ld_err = ERR_BAD_COMMAND;
        end else if (ak_cur == ATYP_IPV4) begin
          if (size == REQ_LEN_V4) ld_tail = TAIL_CONN;
          ld_ptype = DTYPE_IPV4;
        end else if (ak_cur == ATYP_DOMAIN) begin
          if (size == DOMAIN_EXTRA + {1'b0, len_cur}) ld_tail = TAIL_CONN;
          ld_ptype = DTYPE_DOMAIN;
        end else if (ak_cur == ATYP_IPV6) begin
          if (size == REQ_LEN_V6) ld_tail = TAIL_CONN;
          ld_ptype = DTYPE_IPV6;
          ld_ipv6  = 1'b1;
        end else begin
          ld_err = ERR_BAD_ATYP;
        end
        if (ld_tail == TAIL_CONN) phase_next = PH_FWD;
      end
    end else begin
      byte_count_next      = size;
      version_bad_next     = vb_cur;
      count_or_length_next = len_cur;
      no_auth_seen_next    = na_cur;
      if (s_axis_tlast) begin
        ld_tail = TAIL_ERR;
        if (size <= GREET_EXTRA) begin
          ld_err = ERR_INCOMPLETE;
        end else if (vb_cur) begin
          ld_err = ERR_BAD_VERSION;
        end else if (size != GREET_EXTRA + {1'b0, len_cur}) begin
          ld_err = ERR_INCOMPLETE;
        end else if (!na_cur) begin
          ld_err = ERR_NO_AUTH;
        end else begin
          ld_tail    = TAIL_GREET;
          phase_next = PH_REQ;
        end
      end
    end

    // Clear message state at the end of a handshake message
    if ((phase != PH_FWD) && s_axis_tlast) begin
      byte_count_next      = 9'd0;
      version_bad_next     = 1'b0;
      count_or_length_next = 8'd0;
      no_auth_seen_next    = 1'b0;
      command_bad_next     = 1'b0;
      address_kind_next    = 8'd0;
      port_high_next       = 8'd0;
    end
  end

  // Burst length
  always_comb begin
    case (ld_tail)
      TAIL_NONE:  ld_tail_len = 5'd0;
      TAIL_ERR:   ld_tail_len = 5'd1;
      TAIL_GREET: ld_tail_len = 5'd2;
      TAIL_CONN:  ld_tail_len = ld_ipv6 ? CONN_LEN_V6 : CONN_LEN_V4;
      default:    ld_tail_len = 5'd0;
    endcase
  end
  assign ld_len = {4'd0, ld_lead} + ld_tail_len;
  assign ld_has = (ld_len != 5'd0);

  // Update session state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_GREET;
      byte_count      <= 9'd0;
      version_bad     <= 1'b0;
      count_or_length <= 8'd0;
      no_auth_seen    <= 1'b0;
      command_bad     <= 1'b0;
      address_kind    <= 8'd0;
      port_high       <= 8'd0;
    end else if (in_accept) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      version_bad     <= version_bad_next;
      count_or_length <= count_or_length_next;
      no_auth_seen    <= no_auth_seen_next;
      command_bad     <= command_bad_next;
      address_kind    <= address_kind_next;
      port_high       <= port_high_next;
    end
  end

  // Advance the burst sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      pos       <= 5'd0;
    end else if (in_accept && ld_has) begin
      job_valid <= 1'b1;
      pos       <= 5'd0;
    end else if (out_take) begin
      if (out_is_last) begin
        job_valid <= 1'b0;
      end else begin
        pos <= pos + 5'd1;
      end
    end
  end

  // Load burst payload
  always_ff @(posedge clk) begin
    if (in_accept && ld_has) begin
      job_last      <= ld_len - 5'd1;
      job_lead      <= ld_lead;
      job_lead_kind <= ld_lead_kind;
      job_byte      <= b;
      job_type      <= ld_type;
      job_tail      <= ld_tail;
      job_err       <= ld_err;
      job_port      <= {port_high, b};
      job_ptype     <= ld_ptype;
      job_ipv6      <= ld_ipv6;
    end
  end

  // Select the result at the current burst position
  assign t = pos - {4'd0, job_lead};
  always_comb begin
    r_kind = KIND_PASS;
    r_byte = 8'd0;
    r_port = 16'd0;
    r_type = DTYPE_IPV4;
    r_err  = ERR_INCOMPLETE;
    if (job_lead && (pos == 5'd0)) begin
      r_kind = job_lead_kind;
      r_byte = job_byte;
      r_type = job_type;
    end else begin
      case (job_tail)
        TAIL_ERR: begin
          r_kind = KIND_ERROR;
          r_err  = job_err;
        end
        TAIL_GREET: begin
          r_kind = KIND_REPLY;
          r_byte = (t == 5'd0) ? SOCKS_VER : 8'd0;
        end
        TAIL_CONN: begin
          if (t == 5'd0) begin
            r_kind = KIND_PORT;
            r_port = job_port;
            r_type = job_ptype;
          end else begin
            r_kind = KIND_REPLY;
            if (t == 5'd1) r_byte = SOCKS_VER;
            else if (t == 5'd4) r_byte = job_ipv6 ? ATYP_IPV6 : ATYP_IPV4;
          end
        end
        default: begin
          r_kind = KIND_PASS;
        end
      endcase
    end
  end

  assign m_axis_tvalid = job_valid;
  assign m_axis_tuser  = r_kind;
  assign m_axis_tdata  = {3'd0, r_err, r_type, r_port, r_byte};
  assign m_axis_tlast  = out_is_last;

  // Forwarding is final until reset
  a_fwd_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FWD) |=> (phase == PH_FWD))
    else $error("left forwarding phase");

  // Burst position stays inside the burst
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (pos <= job_last))
    else $error("burst position past its end");

  // A taken port result is followed by the reply bytes
  a_port_then_reply: assert property (@(posedge clk) disable iff (rst)
    (job_valid && m_axis_tready && (r_kind == KIND_PORT))
    |=> (job_valid && (r_kind == KIND_REPLY)))
    else $error("port result not followed by reply");

  // A handshake message end clears the byte counter
  a_msg_clear: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_axis_tlast && (phase != PH_FWD)) |=> (byte_count == 9'd0))
    else $error("message state not cleared");

  // A new item is taken only when the burst register frees up
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (in_accept && job_valid) |-> (m_axis_tready && out_is_last))
    else $error("item accepted over a pending burst");

endmodule
